// ----- src/lbm_pkg.sv -----
package lbm_pkg;

    // Command codes carried in s_tuser
    localparam logic [2:0] CMD_BAR   = 3'd0;
    localparam logic [2:0] CMD_DOT   = 3'd1;
    localparam logic [2:0] CMD_PAN   = 3'd2;
    localparam logic [2:0] CMD_TICK  = 3'd3;
    localparam logic [2:0] CMD_FLUSH = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_TRACE_EN  = 2'd0;
    localparam logic [1:0] CFG_SIDE_MASK = 2'd1;
    localparam logic [1:0] CFG_DELAY     = 2'd2;

    localparam logic [1:0] SIDE_MASK_RST = 2'h3;
    localparam logic [7:0] DELAY_RST     = 8'd50;

    typedef enum logic [2:0] {
        CL_BAR,
        CL_DOT,
        CL_PAN,
        CL_TICK,
        CL_FLUSH,
        CL_READ,
        CL_NOP
    } class_t;

    typedef struct packed {
        class_t     cls;
        logic [2:0] strip;
        logic [1:0] sides;
        logic [5:0] level;        // already saturated to the strip length
        logic [6:0] digit_index;
        logic       read_ok;      // digit_index inside the buffer
    } cmd_t;

endpackage

// ----- src/lbm_front.sv -----
module lbm_front #(
    parameter int LEVELS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [23:0]   s_tdata,
    input  logic [2:0]    s_tuser,
    input  logic          hold,
    output logic          q_valid,
    output lbm_pkg::cmd_t q_item,
    input  logic          q_pop
);
    import lbm_pkg::*;

    localparam int MAXL = (LEVELS - 1 < 63) ? LEVELS - 1 : 63;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       item;
    logic       push;
    logic [5:0] lvl;
    logic [6:0] idx;

    assign lvl = s_tdata[10:5];
    assign idx = s_tdata[17:11];

    always_comb
    begin
        item.strip       = s_tdata[2:0];
        item.sides       = s_tdata[4:3];
        item.digit_index = idx;
        item.level       = (7'(lvl) > 7'(MAXL)) ? 6'(MAXL) : lvl;
        item.read_ok     = (10'(idx) < 10'(2 * LEVELS));
        unique case (s_tuser)
            CMD_BAR:   item.cls = CL_BAR;
            CMD_DOT:   item.cls = CL_DOT;
            CMD_PAN:   item.cls = CL_PAN;
            CMD_TICK:  item.cls = CL_TICK;
            CMD_FLUSH: item.cls = CL_FLUSH;
            CMD_READ:  item.cls = CL_READ;
            default:   item.cls = CL_NOP;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

// ----- src/lbm_engine.sv -----
module lbm_engine #(
    parameter int LEVELS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    input  logic          q_valid,
    input  lbm_pkg::cmd_t q_item,
    output logic          q_pop,
    output logic          clearing,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata
);
    import lbm_pkg::*;

    localparam int RW   = $clog2(LEVELS);
    localparam int AW   = $clog2(2 * LEVELS);
    localparam int CNTW = $clog2(LEVELS + 1);
    localparam int CW   = RW + 8;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  fb_mem [2 * LEVELS];
    logic [31:0] ct_mem [2 * LEVELS];
    logic [7:0]  fb_rd_reg;
    logic [31:0] ct_rd_reg;

    logic [AW-1:0] clr_reg, clr_next;
    logic          mode_reg, mode_next;
    logic [1:0]    smask_reg, smask_next;
    logic [7:0]    delay_reg, delay_next;
    logic          half_reg, half_next;
    logic          dirty_reg, dirty_next;
    logic [5:0]    last_dot_reg [8];
    logic [5:0]    last_dot_next [8];

    class_t        op_reg, op_next;
    logic          tdot_reg, tdot_next;
    logic [2:0]    strip_reg, strip_next;
    logic [1:0]    sides_reg, sides_next;
    logic [5:0]    lvl_reg, lvl_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] a0_reg, a0_next;
    logic [AW-1:0] a1_reg, a1_next;
    logic [CNTW-1:0] last_reg, last_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    logic          p_valid_reg, p_valid_next;
    logic [RW-1:0] p_j_reg, p_j_next;
    logic [AW-1:0] p_addr_reg, p_addr_next;
    logic          p_sel_reg, p_sel_next;

    logic [7:0]    rd_hold_reg, rd_hold_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_rd_reg, out_rd_next;
    logic          out_pend_reg, out_pend_next;

    logic [AW-1:0] r_addr, w_addr, issue_addr;
    logic          fb_we, ct_we;
    logic [7:0]    fb_wd;
    logic [31:0]   ct_wd;

    // write-back stage datapath
    logic [CW-1:0] pos, lvl_x, ctr_x;
    logic          lit;
    logic [2:0]    shift;
    logic [7:0]    orm, andm, clr_bits;
    logic [7:0]    lane, lane_dec;
    logic          expire_any;

    // plan datapath
    logic          pl_half;
    logic [AW-1:0] pl_base;
    logic [5:0]    pl_prev;

    assign clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_pend_reg, out_rd_reg};

    assign issue_addr = (op_reg == CL_READ || tdot_reg)
                        ? ((cnt_reg == '0) ? a0_reg : a1_reg)
                        : base_reg + AW'(cnt_reg);
    assign r_addr = issue_addr;
    assign w_addr = clearing ? clr_reg : p_addr_reg;

    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            fb_mem[w_addr] <= fb_wd;
        end
        if (ct_we)
        begin
            ct_mem[w_addr] <= ct_wd;
        end
        fb_rd_reg <= fb_mem[r_addr];
        ct_rd_reg <= ct_mem[r_addr];
    end

    // write-back stage: one row per cycle, read issued the cycle before
    always_comb
    begin
        pos        = CW'(LEVELS - 1) - CW'(p_j_reg);
        lvl_x      = CW'(lvl_reg);
        ctr_x      = CW'(LEVELS / 2);
        shift      = {strip_reg[1:0], 1'b0};
        orm        = 8'(sides_reg) << shift;
        andm       = ~(8'h03 << shift);
        clr_bits   = 8'd0;
        lane       = 8'd0;
        lane_dec   = 8'd0;
        expire_any = 1'b0;
        fb_we      = 1'b0;
        ct_we      = 1'b0;
        fb_wd      = fb_rd_reg;
        ct_wd      = ct_rd_reg;
        unique case (op_reg)
            CL_BAR:  lit = (lvl_x >= pos);
            CL_DOT:  lit = (lvl_x == pos);
            default:
            begin
                if (lvl_x >= ctr_x)
                begin
                    lit = (pos >= ctr_x) && (lvl_x >= pos);
                end
                else
                begin
                    lit = (pos <= ctr_x) && (pos >= lvl_x);
                end
            end
        endcase

        if (clearing)
        begin
            fb_we = 1'b1;
            ct_we = 1'b1;
            fb_wd = 8'd0;
            ct_wd = 32'd0;
        end
        else if (p_valid_reg)
        begin
            if (tdot_reg)
            begin
                ct_we = 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    if (2'(k) == strip_reg[1:0])
                    begin
                        ct_wd[8*k +: 8] = p_sel_reg ? delay_reg : 8'd0;
                    end
                end
                if (!p_sel_reg)
                begin
                    fb_we = 1'b1;
                    fb_wd = fb_rd_reg | orm;
                end
            end
            else if (op_reg == CL_TICK)
            begin
                fb_we = 1'b1;
                ct_we = 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    lane     = ct_rd_reg[8*k +: 8];
                    lane_dec = (lane != 8'd0) ? lane - 8'd1 : 8'd0;
                    ct_wd[8*k +: 8] = lane_dec;
                    if (lane == 8'd1)
                    begin
                        clr_bits   = clr_bits | (8'(smask_reg) << (2 * k));
                        expire_any = 1'b1;
                    end
                end
                fb_wd = fb_rd_reg & ~clr_bits;
            end
            else if (op_reg == CL_READ)
            begin
                fb_we = 1'b0;
            end
            else
            begin
                fb_we = 1'b1;
                fb_wd = lit ? (fb_rd_reg | orm) : (fb_rd_reg & andm);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        mode_next      = mode_reg;
        smask_next     = smask_reg;
        delay_next     = delay_reg;
        half_next      = half_reg;
        dirty_next     = dirty_reg;
        last_dot_next  = last_dot_reg;
        op_next        = op_reg;
        tdot_next      = tdot_reg;
        strip_next     = strip_reg;
        sides_next     = sides_reg;
        lvl_next       = lvl_reg;
        base_next      = base_reg;
        a0_next        = a0_reg;
        a1_next        = a1_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        p_valid_next   = 1'b0;
        p_j_next       = p_j_reg;
        p_addr_next    = p_addr_reg;
        p_sel_next     = p_sel_reg;
        rd_hold_next   = rd_hold_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_rd_next    = out_rd_reg;
        out_pend_next  = out_pend_reg;
        q_pop          = 1'b0;
        pl_half        = q_item.strip[2];
        pl_base        = pl_half ? AW'(LEVELS) : AW'(0);
        pl_prev        = last_dot_reg[q_item.strip];

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRACE_EN:  mode_next  = cfg_data[0];
                CFG_SIDE_MASK: smask_next = cfg_data[1:0];
                CFG_DELAY:     delay_next = cfg_data;
                default:       ;
            endcase
        end

        if (p_valid_reg && op_reg == CL_READ)
        begin
            rd_hold_next = fb_rd_reg;
        end
        if (expire_any && !clearing)
        begin
            dirty_next = 1'b1;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(2 * LEVELS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    op_next      = q_item.cls;
                    tdot_next    = 1'b0;
                    strip_next   = q_item.strip;
                    sides_next   = q_item.sides;
                    lvl_next     = q_item.level;
                    base_next    = pl_base;
                    last_next    = CNTW'(LEVELS - 1);
                    cnt_next     = '0;
                    rd_hold_next = 8'd0;
                    state_next   = ST_RESP;
                    unique case (q_item.cls)
                        CL_BAR, CL_PAN:
                        begin
                            dirty_next = 1'b1;
                            state_next = ST_ISSUE;
                        end
                        CL_DOT:
                        begin
                            dirty_next = 1'b1;
                            state_next = ST_ISSUE;
                            if (mode_reg)
                            begin
                                tdot_next = 1'b1;
                                a0_next   = pl_base + AW'(LEVELS - 1) - AW'(q_item.level);
                                a1_next   = pl_base + AW'(LEVELS - 1) - AW'(pl_prev);
                                if (q_item.level != pl_prev)
                                begin
                                    last_next = CNTW'(1);
                                    last_dot_next[q_item.strip] = q_item.level;
                                end
                                else
                                begin
                                    last_next = CNTW'(0);
                                end
                            end
                        end
                        CL_TICK:
                        begin
                            if (mode_reg)
                            begin
                                // toggle set means the left half is served next
                                half_next  = !half_reg;
                                base_next  = half_reg ? AW'(0) : AW'(LEVELS);
                                state_next = ST_ISSUE;
                            end
                        end
                        CL_READ:
                        begin
                            if (q_item.read_ok)
                            begin
                                a0_next    = AW'(q_item.digit_index);
                                last_next  = CNTW'(0);
                                state_next = ST_ISSUE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                p_valid_next = 1'b1;
                p_j_next     = cnt_reg[RW-1:0];
                p_addr_next  = issue_addr;
                p_sel_next   = (cnt_reg != '0);
                cnt_next     = cnt_reg + CNTW'(1);
                if (cnt_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = rd_hold_reg;
                    out_pend_next  = dirty_reg;
                    if (op_reg == CL_FLUSH)
                    begin
                        dirty_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        tdot_reg    <= tdot_next;
        strip_reg   <= strip_next;
        sides_reg   <= sides_next;
        lvl_reg     <= lvl_next;
        base_reg    <= base_next;
        a0_reg      <= a0_next;
        a1_reg      <= a1_next;
        last_reg    <= last_next;
        cnt_reg     <= cnt_next;
        p_j_reg     <= p_j_next;
        p_addr_reg  <= p_addr_next;
        p_sel_reg   <= p_sel_next;
        rd_hold_reg <= rd_hold_next;
        out_rd_reg  <= out_rd_next;
        out_pend_reg <= out_pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            mode_reg      <= 1'b0;
            smask_reg     <= SIDE_MASK_RST;
            delay_reg     <= DELAY_RST;
            half_reg      <= 1'b0;
            dirty_reg     <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < 8; s++)
            begin
                last_dot_reg[s] <= 6'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            mode_reg      <= mode_next;
            smask_reg     <= smask_next;
            delay_reg     <= delay_next;
            half_reg      <= half_next;
            dirty_reg     <= dirty_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
            last_dot_reg  <= last_dot_next;
        end
    end

endmodule

// ----- src/led_bar_meter_with_trace_decay.sv -----
// Channel   Dir  Fields (low bit first)
// s_*       in   tuser: command[2:0]; tdata: strip, sides, level, digit_index, pad
// m_*       out  tdata: read_data[7:0], update_pending[8], pad
// cfg_*     in   index 0 trace enable, 1 trace_side_mask, 2 trace_delay
//
// Bar, pan, plain dot and an active tick walk every row of one half (one frame
// row per cycle through the buffer and counter memories, read then write back).
// A traced dot visits the new row and, if the level moved, the old row; an
// in-range read reads one entry. Flush, idle tick, out-of-range read and unused
// codes go straight to the result step. After reset a clearing pass zeroes
// both memories with s_tready low. Up to two beats queue ahead of the engine; a
// stalled output beat holds the engine only at its result step.
module led_bar_meter_with_trace_decay #(
    parameter int LEVELS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // strip[2:0], sides[4:3], level[10:5], digit_index[17:11]
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_data[7:0], update_pending[8]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import lbm_pkg::*;

    logic q_valid, q_pop, clearing;
    cmd_t q_item;

    // front: accepts beats, decodes command, saturates level
    lbm_front #(.LEVELS(LEVELS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .hold     (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: walks the frame buffer and trace counters, owns the result register
    lbm_engine #(.LEVELS(LEVELS)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- src/lbm_checker.sv -----
module lbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:9] == 7'd0))
        else $error("output padding not zero");

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !s_tready && !m_tvalid)
        else $error("input taken during clearing pass");

endmodule

bind led_bar_meter_with_trace_decay lbm_checker u_lbm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbm_pkg::*;

    localparam int LEVELS = 64;
    localparam int CENTRE = LEVELS / 2;
    localparam int HALF_CTRS = 4 * LEVELS;

    // Meter model plus queue of expected output beats
    class meter_scoreboard;
        logic [7:0]  fbuf [2*LEVELS];
        logic [7:0]  ctr [2*HALF_CTRS];
        logic [5:0]  last_lvl [8];
        logic        half_sel;
        logic        dirty;
        logic        mode;
        logic [1:0]  side_mask;
        logic [7:0]  delay;
        logic [15:0] pending_beats [$];
        int          errors;

        function void init();
            foreach (fbuf[i]) fbuf[i] = '0;
            foreach (ctr[i]) ctr[i] = '0;
            foreach (last_lvl[i]) last_lvl[i] = '0;
            half_sel = 1'b0;
            dirty = 1'b0;
            mode = 1'b0;
            side_mask = SIDE_MASK_RST;
            delay = DELAY_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            if (idx == CFG_TRACE_EN)
                mode = val[0];
            else if (idx == CFG_SIDE_MASK)
                side_mask = val[1:0];
            else if (idx == CFG_DELAY)
                delay = val;
        endfunction

        // mode_sel: CMD_BAR, CMD_DOT or CMD_PAN
        function void paint(int s, logic [1:0] sd, int lvl, logic [2:0] mode_sel);
            int  sh;
            int  base;
            bit  lit;
            sh = (s & 3) * 2;
            base = (s & 4) ? LEVELS : 0;
            for (int i = 0; i < LEVELS; i++)
            begin
                if (mode_sel == CMD_BAR)
                    lit = lvl >= i;
                else if (mode_sel == CMD_DOT)
                    lit = lvl == i;
                else if (lvl >= CENTRE)
                    lit = i >= CENTRE && lvl >= i;
                else
                    lit = i <= CENTRE && i >= lvl;
                if (lit)
                    fbuf[base + LEVELS - 1 - i] |= 8'(sd) << sh;
                else
                    fbuf[base + LEVELS - 1 - i] &= ~(8'd3 << sh);
            end
            dirty = 1'b1;
        endfunction

        function void traced_dot(int s, logic [1:0] sd, int lvl);
            int sh;
            int hf;
            int cb;
            int prev;
            sh = (s & 3) * 2;
            hf = (s & 4) ? 1 : 0;
            cb = hf * HALF_CTRS + (s & 3);
            prev = last_lvl[s];
            fbuf[hf * LEVELS + LEVELS - 1 - lvl] |= 8'(sd) << sh;
            ctr[cb + ((LEVELS - 1 - lvl) << 2)] = '0;
            if (lvl != prev)
            begin
                ctr[cb + ((LEVELS - 1 - prev) << 2)] = delay;
                last_lvl[s] = 6'(lvl);
            end
            dirty = 1'b1;
        endfunction

        function void decay_tick();
            int hf;
            if (!mode)
                return;
            hf = half_sel ? 0 : 1;
            half_sel = !half_sel;
            for (int i = 0; i < HALF_CTRS; i++)
            begin
                if (ctr[hf * HALF_CTRS + i] != 0)
                begin
                    ctr[hf * HALF_CTRS + i]--;
                    if (ctr[hf * HALF_CTRS + i] == 0)
                    begin
                        fbuf[hf * LEVELS + (i >> 2)] &= ~(8'(side_mask) << ((i & 3) * 2));
                        dirty = 1'b1;
                    end
                end
            end
        endfunction

        function void note_beat(logic [2:0] cmd, logic [23:0] data);
            int          s;
            logic [1:0]  sd;
            int          lvl;
            int          idx;
            logic [7:0]  rd;
            logic        pend;
            s = data[2:0];
            sd = data[4:3];
            lvl = data[10:5];
            idx = data[17:11];
            rd = '0;
            case (cmd)
                CMD_BAR: paint(s, sd, lvl, CMD_BAR);
                CMD_DOT:
                    if (mode)
                        traced_dot(s, sd, lvl);
                    else
                        paint(s, sd, lvl, CMD_DOT);
                CMD_PAN: paint(s, sd, lvl, CMD_PAN);
                CMD_TICK: decay_tick();
                CMD_READ: if (idx < 2 * LEVELS) rd = fbuf[idx];
                default: ;
            endcase
            pend = dirty;
            if (cmd == CMD_FLUSH)
                dirty = 1'b0;
            pending_beats.push_back({7'd0, pend, rd});
        endfunction

        task report(string what, int exp_v, int got_v);
            $display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
            errors++;
        endtask

        task check_beat(logic [15:0] got);
            logic [15:0] exp_beat;
            if (pending_beats.size() == 0)
            begin
                report("output beat with nothing expected", 0, int'(got));
                return;
            end
            exp_beat = pending_beats.pop_front();
            if (got[7:0] !== exp_beat[7:0])
                report("read_data", int'(exp_beat[7:0]), int'(got[7:0]));
            if (got[8] !== exp_beat[8])
                report("update_pending", int'(exp_beat[8]), int'(got[8]));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    meter_scoreboard sb;
    bit              rx_stall_on = 1'b0;
    int              beats_sent;

    led_bar_meter_with_trace_decay #(.LEVELS(LEVELS)) i_dut (.*);

    always #4 clk = ~clk;

    // Output side: check on rising edge, move tready on falling edge
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata);

    // Receiver: long quiet stretches, then random stalls
    always @(negedge clk)
    begin
        if (!rx_stall_on)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(negedge clk)
        if ($urandom_range(0, 199) == 0)
            rx_stall_on <= !rx_stall_on;

    // One beat, held until accepted. Valid stays high across back-to-back beats.
    task automatic send_beat(logic [2:0] cmd, logic [2:0] s, logic [1:0] sd,
                             logic [5:0] lvl, logic [6:0] idx);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'd0, idx, lvl, sd, s};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_beat(cmd, {6'd0, idx, lvl, sd, s});
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Let the queue drain, then cover the engine's longest pass
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_beats.size() != 0)
            @(negedge clk);
        repeat (LEVELS + 10) @(negedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random beat mostly built around dots and ticks so traces actually expire
    task automatic random_beat();
        int         r;
        logic [2:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 30) cmd = CMD_DOT;
        else if (r < 55) cmd = CMD_TICK;
        else if (r < 63) cmd = CMD_BAR;
        else if (r < 70) cmd = CMD_PAN;
        else if (r < 76) cmd = CMD_FLUSH;
        else if (r < 97) cmd = CMD_READ;
        else cmd = 3'($urandom_range(6, 7));
        send_beat(cmd, 3'($urandom), 2'($urandom),
                  ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(28, 36)),
                  7'($urandom));
    endtask

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int         burst;
        logic [7:0] delays [4];
        sb = new();
        sb.init();
        beats_sent = 0;
        delays = '{8'd1, 8'd2, 8'd0, 8'd255};
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: every command, extremes, odd side values
        send_beat(CMD_BAR, 3'd0, 2'd3, 6'd63, 7'd0);
        send_beat(CMD_BAR, 3'd7, 2'd1, 6'd0, 7'd0);
        send_beat(CMD_PAN, 3'd3, 2'd2, 6'd40, 7'd0);
        send_beat(CMD_PAN, 3'd4, 2'd3, 6'd5, 7'd0);
        send_beat(CMD_DOT, 3'd1, 2'd0, 6'd10, 7'd0);
        send_beat(CMD_DOT, 3'd5, 2'd3, 6'd32, 7'd0);
        send_beat(CMD_TICK, 3'd0, 2'd0, 6'd0, 7'd0);
        send_beat(CMD_READ, 3'd0, 2'd0, 6'd0, 7'd0);
        send_beat(CMD_READ, 3'd0, 2'd0, 6'd0, 7'd63);
        send_beat(CMD_READ, 3'd0, 2'd0, 6'd0, 7'd127);
        send_beat(CMD_FLUSH, 3'd0, 2'd0, 6'd0, 7'd0);
        send_beat(CMD_FLUSH, 3'd0, 2'd0, 6'd0, 7'd0);
        send_beat(3'd6, 3'd7, 2'd3, 6'd63, 7'd127);
        send_beat(3'd7, 3'd0, 2'd0, 6'd0, 7'd0);
        drain();

        // Traced dots: same position, new position, expiry on both halves
        set_reg(CFG_TRACE_EN, 8'd1);
        set_reg(CFG_DELAY, 8'd1);
        set_reg(CFG_SIDE_MASK, 8'd1);
        send_beat(CMD_DOT, 3'd2, 2'd3, 6'd20, 7'd0);
        send_beat(CMD_DOT, 3'd2, 2'd3, 6'd20, 7'd0);
        send_beat(CMD_DOT, 3'd6, 2'd3, 6'd63, 7'd0);
        send_beat(CMD_DOT, 3'd6, 2'd3, 6'd1, 7'd0);
        send_beat(CMD_TICK, 3'd0, 2'd0, 6'd0, 7'd0);
        send_beat(CMD_TICK, 3'd0, 2'd0, 6'd0, 7'd0);
        send_beat(CMD_READ, 3'd0, 2'd0, 6'd0, 7'd64);
        send_beat(CMD_READ, 3'd0, 2'd0, 6'd0, 7'd43);
        drain();

        // Random phases across settings; pause until all results are back each time
        for (int ph = 0; ph < 8; ph++)
        begin
            set_reg(CFG_TRACE_EN, 8'(ph != 3));
            set_reg(CFG_SIDE_MASK, 8'(ph % 4));
            set_reg(CFG_DELAY, (ph < 4) ? delays[ph] : 8'($urandom_range(0, 6)));
            for (int n = 0; n < 235;)
            begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst; k++)
                    random_beat();
                n += burst;
                if ($urandom_range(0, 2) == 0)
                    idle_gap($urandom_range(1, 30));
            end
            drain();
        end

        drain();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/lbm_pkg.sv
src/lbm_front.sv
src/lbm_engine.sv
src/led_bar_meter_with_trace_decay.sv
src/lbm_checker.sv
verif/tb.sv
